>>> rtl/ncv_pkg.sv
// Package for the NMEA 0183 checksum validator.
// Holds the channel payload types, the classified-byte type and the hex decode.
// No dependencies.
package ncv_pkg;

  localparam logic [7:0] STAR_CHAR   = 8'h2A;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_sentence;
  } in_t;

  typedef struct packed {
    logic       checksum_ok;
    logic       format_ok;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
  } out_t;

  // One byte after classification by the front end.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_star;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/ncv_front.sv
// Front end: accepts sentence bytes and classifies them (star, hex digit).
// Uses ncv_pkg types and hex_decode.
module ncv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ncv_pkg::in_t  in_data,
  output logic          item_valid,
  input  logic          item_ready,
  output ncv_pkg::item_t item
);

  logic         valid_q;
  ncv_pkg::item_t item_q;
  ncv_pkg::hex_t  hex;

  assign hex        = ncv_pkg::hex_decode(in_data.char_byte);
  assign in_ready   = !valid_q || item_ready;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_q.char_byte <= in_data.char_byte;
      item_q.is_star   <= (in_data.char_byte == ncv_pkg::STAR_CHAR);
      item_q.hex_ok    <= hex.ok;
      item_q.hex_val   <= hex.val;
      item_q.last      <= in_data.end_of_sentence;
    end
  end

endmodule

>>> rtl/ncv_queue.sv
// Short request queue between the front end and the back end.
// Uses ncv_pkg::item_t.
module ncv_queue #(
  parameter int unsigned DEPTH = ncv_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ncv_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ncv_pkg::item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ncv_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           wr;
  logic           rd;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign wr         = push_valid && push_ready;
  assign rd         = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
    if (wr) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/ncv_back.sv
// Back end: keeps the running XOR and star capture per sentence and
// registers one result on the final byte. Uses ncv_pkg types.
module ncv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ncv_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output ncv_pkg::out_t  out_data
);

  logic       at_first_byte, at_first_byte_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] snapshot, snapshot_next;
  logic       star_seen, star_seen_next;
  logic [1:0] chars_after_star, chars_after_star_next;
  logic       d1_ok, d1_ok_next;
  logic [3:0] d1_val, d1_val_next;
  logic       d2_ok, d2_ok_next;
  logic [3:0] d2_val, d2_val_next;

  logic          take;
  logic          fmt;
  logic [7:0]    rx;
  logic [7:0]    cmp;
  ncv_pkg::out_t result;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    at_first_byte_next    = 1'b0;
    snapshot_next         = snapshot;
    star_seen_next        = star_seen;
    chars_after_star_next = chars_after_star;
    d1_ok_next            = d1_ok;
    d1_val_next           = d1_val;
    d2_ok_next            = d2_ok;
    d2_val_next           = d2_val;
    running_xor_next      = at_first_byte ? running_xor : running_xor ^ item.char_byte;

    if (item.is_star) begin
      snapshot_next         = at_first_byte ? 8'd0 : running_xor;
      star_seen_next        = 1'b1;
      chars_after_star_next = 2'd0;
      d1_ok_next            = 1'b0;
      d1_val_next           = 4'd0;
      d2_ok_next            = 1'b0;
      d2_val_next           = 4'd0;
    end else if (star_seen && chars_after_star != 2'd2) begin
      if (chars_after_star == 2'd0) begin
        d1_ok_next  = item.hex_ok;
        d1_val_next = item.hex_val;
      end else begin
        d2_ok_next  = item.hex_ok;
        d2_val_next = item.hex_val;
      end
      chars_after_star_next = chars_after_star + 2'd1;
    end

    fmt = star_seen_next && (chars_after_star_next == 2'd2) && d1_ok_next;
    cmp = star_seen_next ? snapshot_next : 8'd0;
    if (!fmt) begin
      rx = 8'd0;
    end else if (d2_ok_next) begin
      rx = {d1_val_next, d2_val_next};
    end else begin
      rx = {4'd0, d1_val_next};
    end

    result.checksum_ok       = fmt && (rx == cmp);
    result.format_ok         = fmt;
    result.computed_checksum = cmp;
    result.received_checksum = rx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_byte    <= 1'b1;
      running_xor      <= 8'd0;
      snapshot         <= 8'd0;
      star_seen        <= 1'b0;
      chars_after_star <= 2'd0;
      d1_ok            <= 1'b0;
      d1_val           <= 4'd0;
      d2_ok            <= 1'b0;
      d2_val           <= 4'd0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(take && item.last)) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (item.last) begin
          // start the next sentence from the reset state
          at_first_byte    <= 1'b1;
          running_xor      <= 8'd0;
          snapshot         <= 8'd0;
          star_seen        <= 1'b0;
          chars_after_star <= 2'd0;
          d1_ok            <= 1'b0;
          d1_val           <= 4'd0;
          d2_ok            <= 1'b0;
          d2_val           <= 4'd0;
          out_valid        <= 1'b1;
        end else begin
          at_first_byte    <= at_first_byte_next;
          running_xor      <= running_xor_next;
          snapshot         <= snapshot_next;
          star_seen        <= star_seen_next;
          chars_after_star <= chars_after_star_next;
          d1_ok            <= d1_ok_next;
          d1_val           <= d1_val_next;
          d2_ok            <= d2_ok_next;
          d2_val           <= d2_val_next;
        end
      end
    end
    if (take && item.last) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/nmea_checksum_validator_top.sv
// Channel  Signals                       Payload
// in       in_valid / in_ready           in_data  (char_byte, end_of_sentence)
// out      out_valid / out_ready         out_data (checksum_ok, format_ok,
//                                                  computed_checksum, received_checksum)
//
// One byte per cycle sustained while the output is not stalled.
// Path: classify register, request queue, sentence state and output register.
// rst is synchronous, active high, and starts a fresh sentence.
// A stalled output holds the back end; the queue lets the front keep taking bytes until it fills.
// Top level of the NMEA 0183 checksum validator.
// Depends on ncv_pkg, ncv_front, ncv_queue and ncv_back.
module nmea_checksum_validator_top #(
  parameter int unsigned QUEUE_DEPTH = ncv_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ncv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ncv_pkg::out_t out_data
);

  logic           f_valid, f_ready;
  ncv_pkg::item_t f_item;
  logic           q_valid, q_ready;
  ncv_pkg::item_t q_item;

  ncv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  ncv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  ncv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
